/* rtl/atan2_polynomial_macros.svh */
// Assertion macros for the atan2 polynomial block.
`ifndef ATAN2_POLYNOMIAL_MACROS_SVH
`define ATAN2_POLYNOMIAL_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ATP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ATP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/atp_pkg.sv */
// Shared types and constants for the atan2 polynomial block.
`timescale 1ns / 1ps
package atp_pkg;
    localparam int QBITS = 30;

    localparam logic signed [31:0] C_COEF [7] = '{
        32'sd7744777,
        -32'sd37645046,
        32'sd87698811,
        -32'sd143609290,
        32'sd213208227,
        -32'sd357824448,
        32'sd1073741824
    };

    localparam logic signed [33:0] PI_Q      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q = 34'sd1686629713;

    typedef struct packed {
        logic valid;
        logic zero;
        logic ybig;
        logic xneg;
        logic yneg;
    } t_side;
endpackage

/* rtl/atp_div_stage.sv */
// One registered step of the restoring ratio divider.
`timescale 1ns / 1ps
module atp_div_stage
    import atp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_side                 i_side,
    input  logic [COORD_BITS-1:0] i_hi,
    input  logic [COORD_BITS-1:0] i_rem,
    input  logic [QBITS:0]        i_nlow,
    input  logic [QBITS:0]        i_quo,
    output t_side                 o_side,
    output logic [COORD_BITS-1:0] o_hi,
    output logic [COORD_BITS-1:0] o_rem,
    output logic [QBITS:0]        o_nlow,
    output logic [QBITS:0]        o_quo
);
    logic [COORD_BITS:0]   w_trial;
    logic                  w_bit;
    logic [COORD_BITS-1:0] n_rem;

    always_comb begin
        w_trial = {i_rem, i_nlow[QBITS]};
        w_bit   = (w_trial >= {1'b0, i_hi});
        if (w_bit) begin
            n_rem = COORD_BITS'(w_trial - {1'b0, i_hi});
        end else begin
            n_rem = w_trial[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_en) begin
            o_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hi   <= i_hi;
            o_rem  <= n_rem;
            o_nlow <= {i_nlow[QBITS-1:0], 1'b0};
            o_quo  <= {i_quo[QBITS-1:0], w_bit};
        end
    end
endmodule

/* rtl/atp_mac_stage.sv */
// One registered Horner step: rounded signed-by-unsigned product plus a constant.
`timescale 1ns / 1ps
module atp_mac_stage
    import atp_pkg::*;
#(
    parameter logic signed [31:0] ADD = 32'sd0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_side              i_side,
    input  logic signed [31:0] i_acc,
    input  logic [QBITS:0]     i_mul,
    input  logic [QBITS:0]     i_s,
    input  logic [QBITS:0]     i_q,
    output t_side              o_side,
    output logic signed [31:0] o_acc,
    output logic [QBITS:0]     o_s,
    output logic [QBITS:0]     o_q
);
    logic        w_neg;
    logic [31:0] w_mag;
    logic [63:0] w_prod;
    logic [31:0] w_p;
    logic signed [31:0] n_acc;

    always_comb begin
        w_neg  = i_acc[31];
        w_mag  = w_neg ? (~i_acc + 32'd1) : i_acc;
        w_prod = 64'(w_mag) * 64'(i_mul);
        w_p    = 32'((w_prod + (64'd1 << (QBITS - 1))) >> QBITS);
        n_acc  = (w_neg ? -$signed(w_p) : $signed(w_p)) + ADD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_en) begin
            o_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_acc <= n_acc;
            o_s   <= i_s;
            o_q   <= i_q;
        end
    end
endmodule

/* rtl/atan2_polynomial.sv */
// Top level of the pipelined four-quadrant arctangent.
//  channel  dir  fields (low bit up)
//  s        in   tdata: y_coord, x_coord
//  m        out  tdata: angle (Q3.ANGLE_FRAC_BITS)
// One pair per clock unless the master side stalls. Stages: magnitude, sort, 31 divider
// steps (one bit per stage), square, 7 Horner, fold, output; the divider sets the depth.
// Reset (synchronous, active low) clears the valid bits and side flags only.
// A stall on the master side freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "atan2_polynomial_macros.svh"
module atan2_polynomial
    import atp_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // y_coord, x_coord
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]        i_s_tdata,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // angle
    output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0]   o_m_tdata
);
    localparam int C   = COORD_BITS;
    localparam int AW  = ANGLE_FRAC_BITS + 3;
    localparam int OW  = ((AW + 7) / 8) * 8;
    localparam int SH  = QBITS - ANGLE_FRAC_BITS;
    localparam int NQ  = QBITS + 1;
    localparam logic [33:0] PI_OUT = (34'(PI_Q) + (34'd1 << (SH - 1))) >> SH;

    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // magnitudes and signs
    logic [C-1:0] w_y, w_x, n_ay, n_ax;
    t_side        n_side_a, r_side_a;
    logic [C-1:0] r_ay, r_ax;

    always_comb begin
        w_y  = i_s_tdata[C-1:0];
        w_x  = i_s_tdata[2*C-1:C];
        n_ay = w_y[C-1] ? (~w_y + 1'b1) : w_y;
        n_ax = w_x[C-1] ? (~w_x + 1'b1) : w_x;
        n_side_a       = '0;
        n_side_a.valid = i_s_tvalid;
        n_side_a.yneg  = w_y[C-1];
        n_side_a.xneg  = w_x[C-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_a <= '0;
        end else if (w_en) begin
            r_side_a <= n_side_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ay <= n_ay;
            r_ax <= n_ax;
        end
    end

    // sort and build the dividend
    logic          w_ybig;
    logic [C-1:0]  w_hi, w_lo;
    logic [C+29:0] w_num;
    t_side         n_side_b;

    always_comb begin
        w_ybig = r_ay > r_ax;
        w_hi   = w_ybig ? r_ay : r_ax;
        w_lo   = w_ybig ? r_ax : r_ay;
        w_num  = {w_lo, {QBITS{1'b0}}} + (C+30)'(w_hi >> 1);
        n_side_b      = r_side_a;
        n_side_b.ybig = w_ybig;
        n_side_b.zero = (w_hi == '0);
    end

    t_side        w_side [NQ+1];
    logic [C-1:0] w_hi_d [NQ+1];
    logic [C-1:0] w_rem  [NQ+1];
    logic [QBITS:0] w_nlow [NQ+1];
    logic [QBITS:0] w_quo  [NQ+1];

    t_side          r_side_b;
    logic [C-1:0]   r_hi_b;
    logic [C-1:0]   r_rem_b;
    logic [QBITS:0] r_nlow_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_b <= '0;
        end else if (w_en) begin
            r_side_b <= n_side_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hi_b   <= w_hi;
            r_rem_b  <= C'(w_num >> NQ);
            r_nlow_b <= w_num[QBITS:0];
        end
    end

    assign w_side[0] = r_side_b;
    assign w_hi_d[0] = r_hi_b;
    assign w_rem[0]  = r_rem_b;
    assign w_nlow[0] = r_nlow_b;
    assign w_quo[0]  = '0;

    for (genvar g = 0; g < NQ; g++) begin : g_div
        atp_div_stage #(.COORD_BITS(C)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_side[g]),
            .i_hi    (w_hi_d[g]),
            .i_rem   (w_rem[g]),
            .i_nlow  (w_nlow[g]),
            .i_quo   (w_quo[g]),
            .o_side  (w_side[g+1]),
            .o_hi    (w_hi_d[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_nlow  (w_nlow[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    // square of the ratio
    t_side          r_side_s;
    logic [QBITS:0] r_s, r_q;
    logic [61:0]    w_sq;

    assign w_sq = 62'(w_quo[NQ]) * 62'(w_quo[NQ]) + (62'd1 << (QBITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_s <= '0;
        end else if (w_en) begin
            r_side_s <= w_side[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s <= w_sq[QBITS+QBITS:QBITS];
            r_q <= w_quo[NQ];
        end
    end

    // Horner chain, then the final product by the ratio
    t_side              w_hside [8];
    logic signed [31:0] w_acc   [8];
    logic [QBITS:0]     w_hs    [8];
    logic [QBITS:0]     w_hq    [8];

    assign w_hside[0] = r_side_s;
    assign w_acc[0]   = C_COEF[0];
    assign w_hs[0]    = r_s;
    assign w_hq[0]    = r_q;

    for (genvar k = 1; k < 8; k++) begin : g_mac
        atp_mac_stage #(.ADD((k < 7) ? C_COEF[k % 7] : 32'sd0)) u_mac (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_hside[k-1]),
            .i_acc   (w_acc[k-1]),
            .i_mul   ((k < 7) ? w_hs[k-1] : w_hq[k-1]),
            .i_s     (w_hs[k-1]),
            .i_q     (w_hq[k-1]),
            .o_side  (w_hside[k]),
            .o_acc   (w_acc[k]),
            .o_s     (w_hs[k]),
            .o_q     (w_hq[k])
        );
    end

    // octant fold
    t_side              r_side_f;
    logic signed [33:0] r_fold, n_fold, w_f1, w_f2;

    always_comb begin
        w_f1   = w_hside[7].ybig ? (HALF_PI_Q - 34'(w_acc[7])) : 34'(w_acc[7]);
        w_f2   = w_hside[7].xneg ? (PI_Q - w_f1) : w_f1;
        n_fold = w_hside[7].yneg ? -w_f2 : w_f2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_f <= '0;
        end else if (w_en) begin
            r_side_f <= w_hside[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fold <= n_fold;
        end
    end

    // rounding to the output format
    logic [33:0]   w_mag, w_rmag;
    logic [AW-1:0] n_angle, r_angle;
    logic          r_out_valid;

    always_comb begin
        w_mag  = r_fold[33] ? (~r_fold + 34'd1) : r_fold;
        w_rmag = (w_mag + (34'd1 << (SH - 1))) >> SH;
        if (r_side_f.zero) begin
            n_angle = '0;
        end else if (r_fold[33]) begin
            n_angle = AW'(34'd0 - w_rmag);
        end else begin
            n_angle = AW'(w_rmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_side_f.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OW'(r_angle);

    logic w_range_ok, w_zero_due, w_zero_ok, w_ratio_due, w_ratio_ok;

    assign w_range_ok  = ($signed(r_angle) <= $signed({1'b0, PI_OUT[AW-1:0]}))
                      && ($signed(r_angle) >= -$signed({1'b0, PI_OUT[AW-1:0]}));
    assign w_zero_due  = w_en && r_side_f.valid && r_side_f.zero;
    assign w_zero_ok   = o_m_tvalid && (r_angle == '0);
    assign w_ratio_due = w_side[NQ].valid && !w_side[NQ].zero;
    assign w_ratio_ok  = w_quo[NQ] <= (NQ'(1) << QBITS);

    `ATP_ASSERT_NOW(a_angle_range, i_clk, i_rst_n, o_m_tvalid, w_range_ok, "angle beyond pi")
    `ATP_ASSERT_NEXT(a_zero_out, i_clk, i_rst_n, w_zero_due, w_zero_ok, "zero vector angle")
    `ATP_ASSERT_NOW(a_ratio_max, i_clk, i_rst_n, w_ratio_due, w_ratio_ok, "ratio above one")
endmodule
